[design/shcp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package shcp_pkg;

    // command codes
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // register select codes
    localparam logic [1:0] REG_CTRL   = 2'd0;
    localparam logic [1:0] REG_STATUS = 2'd1;
    localparam logic [1:0] REG_BUFFER = 2'd2;

    // control register bit positions
    localparam int CTRL_SPIE = 7;
    localparam int CTRL_SPE  = 6;
    localparam int CTRL_DORD = 5;
    localparam int CTRL_MSTR = 4;
    localparam int CTRL_CPOL = 3;
    localparam int CTRL_CPHA = 2;

    // status register bit positions
    localparam int STAT_SPIF = 7;
    localparam int STAT_WCOL = 6;
    localparam int STAT_2X   = 0;

    // clock edges in one byte frame
    localparam logic [4:0] FRAME_EDGES = 5'd16;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_LEAD   = 2'd1,
        MODE_FOLLOW = 2'd2
    } t_mode;

    typedef struct packed {
        logic [1:0] command;
        logic [1:0] reg_sel;
        logic [7:0] write_value;
        logic       sck_in;
        logic       mosi_in;
        logic       miso_in;
        logic       ss_n_in;
        logic       ss_pin_is_input;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] read_data;
        logic       sck_out;
        logic       mosi_out;
        logic       miso_out;
        logic       miso_drive;
        logic       irq;
        logic       busy_res;
    } t_out_beat;

    typedef struct packed {
        logic [7:0] control_reg;
        logic       flag_bit;
        logic       collision_bit;
        logic       double_speed;
        logic [7:0] data_latch;
        logic [7:0] shifter;
        logic [4:0] edge_count;
        logic [6:0] half_bit_timer;
        logic       transfer_active;
        logic [7:0] rx_byte;
        logic       rx_loaded;
        logic       status_seen;
        logic       clock_level;
        logic       selected_flag;
        logic       prev_sck;
        logic       drive_bit;
    } t_state;

    // clock divider factor for each SPR code
    function automatic logic [7:0] rate_factor(input logic [1:0] spr);
        logic [7:0] f;
        case (spr)
            2'd0:    f = 8'd4;
            2'd1:    f = 8'd16;
            2'd2:    f = 8'd64;
            default: f = 8'd128;
        endcase
        return f;
    endfunction

endpackage
`default_nettype wire

[design/spi_host_client_peripheral_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  handshake           payload
// input     in         i_valid / o_stall   i_in  (t_in_beat)
// output    out        o_valid / i_stall   o_out (t_out_beat)
//
// each beat (read, write or tick) is applied to the register state in the cycle
// it is accepted; its result appears on o_out in the cycle after
// sustained rate is one beat per cycle while i_stall is low, limited by the single result register
// a stalled result holds; a new beat is taken in the cycle the old one leaves
// synchronous active-low reset clears all controller state and the result valid
module spi_host_client_peripheral_core
    import shcp_pkg::*;
(
    input  wire       i_clk,
    input  wire       i_rst_n,
    input  wire       i_valid,
    output logic      o_stall,
    input  t_in_beat  i_in,
    output logic      o_valid,
    input  wire       i_stall,
    output t_out_beat o_out
);

    t_state    r_state;
    t_state    n_state;
    t_out_beat n_out;
    t_out_beat r_out;
    logic      r_out_valid;
    logic      w_accept;

    shcp_step u_step (
        .i_state (r_state),
        .i_beat  (i_in),
        .o_state (n_state),
        .o_beat  (n_out)
    );

    // room when the result register is empty or being taken this cycle
    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule
`default_nettype wire

[design/shcp_step.sv]
`timescale 1ns / 1ps
`default_nettype none
module shcp_step
    import shcp_pkg::*;
(
    input  t_state    i_state,
    input  t_in_beat  i_beat,
    output t_state    o_state,
    output t_out_beat o_beat
);

    function automatic t_mode cur_mode(input logic [7:0] c);
        t_mode m;
        if (!c[CTRL_SPE]) begin
            m = MODE_OFF;
        end else if (c[CTRL_MSTR]) begin
            m = MODE_LEAD;
        end else begin
            m = MODE_FOLLOW;
        end
        return m;
    endfunction

    function automatic logic [6:0] half_bit(input logic [7:0] c, input logic ds);
        logic [7:0] f;
        f = rate_factor(c[1:0]);
        if (ds) begin
            f = f >> 1;
        end
        f = f >> 1;
        if (f == 8'd0) begin
            f = 8'd1;
        end
        return f[6:0];
    endfunction

    function automatic logic front_bit(input t_state s);
        return s.control_reg[CTRL_DORD] ? s.shifter[0] : s.shifter[7];
    endfunction

    function automatic t_state frame_start(input t_state s_in);
        t_state s;
        s = s_in;
        s.transfer_active = 1'b1;
        s.edge_count = 5'd0;
        if (!s.control_reg[CTRL_CPHA]) begin
            s.drive_bit = front_bit(s);
        end
        return s;
    endfunction

    // one edge at the new level; latches the byte at frame end
    function automatic t_state clock_edge(input t_state s_in, input logic level,
                                          input logic din);
        t_state s;
        logic   leading;
        s = s_in;
        leading = (level != s.control_reg[CTRL_CPOL]);
        s.edge_count = s.edge_count + 5'd1;
        if (leading != s.control_reg[CTRL_CPHA]) begin
            if (s.control_reg[CTRL_DORD]) begin
                s.shifter = {din, s.shifter[7:1]};
            end else begin
                s.shifter = {s.shifter[6:0], din};
            end
        end else begin
            s.drive_bit = front_bit(s);
        end
        if (s.edge_count >= FRAME_EDGES) begin
            s.rx_byte = s.shifter;
            s.rx_loaded = 1'b1;
            s.flag_bit = 1'b1;
            s.edge_count = 5'd0;
        end
        return s;
    endfunction

    function automatic logic frame_done(input t_state s);
        logic [4:0] e;
        e = s.edge_count + 5'd1;
        return e >= FRAME_EDGES;
    endfunction

    function automatic t_state client_select(input t_state s_in, input logic sel);
        t_state s;
        s = s_in;
        if (sel && !s.transfer_active) begin
            s = frame_start(s);
        end else if (!sel && s.transfer_active) begin
            s.transfer_active = 1'b0;
            s.edge_count = 5'd0;
        end
        return s;
    endfunction

    function automatic t_state select_update(input t_state s_in, input logic sel);
        t_state s;
        t_mode  m;
        s = s_in;
        m = cur_mode(s.control_reg);
        s.selected_flag = sel;
        if (m == MODE_LEAD) begin
            // select pulled low by another host: fall back to client
            if (sel) begin
                s.control_reg[CTRL_MSTR] = 1'b0;
                s.transfer_active = 1'b0;
                s.half_bit_timer = 7'd0;
                s.edge_count = 5'd0;
                s = client_select(s, sel);
                s.flag_bit = 1'b1;
            end
        end else if (m == MODE_FOLLOW) begin
            s = client_select(s, sel);
        end
        return s;
    endfunction

    function automatic t_state apply_mode(input t_state s_in, input t_mode old_m,
                                          input t_mode new_m);
        t_state s;
        s = s_in;
        if (old_m != new_m) begin
            s.transfer_active = 1'b0;
            s.half_bit_timer = 7'd0;
            s.edge_count = 5'd0;
            if (new_m == MODE_LEAD) begin
                s.clock_level = s.control_reg[CTRL_CPOL];
            end
            s = select_update(s, s.selected_flag);
        end
        return s;
    endfunction

    t_state     s;
    t_mode      m_old;
    t_mode      m;
    logic [7:0] rd;
    logic       done;

    always_comb begin
        s = i_state;
        rd = 8'd0;
        m_old = cur_mode(s.control_reg);
        done = 1'b0;
        case (i_beat.command)
            CMD_READ: begin
                case (i_beat.reg_sel)
                    REG_CTRL: begin
                        rd = s.control_reg;
                    end
                    REG_STATUS: begin
                        rd[STAT_SPIF] = s.flag_bit;
                        rd[STAT_WCOL] = s.collision_bit;
                        rd[STAT_2X] = s.double_speed;
                        if (s.flag_bit || s.collision_bit) begin
                            s.status_seen = 1'b1;
                        end
                    end
                    REG_BUFFER: begin
                        if (s.rx_loaded) begin
                            s.data_latch = s.rx_byte;
                            s.rx_loaded = 1'b0;
                        end
                        rd = s.data_latch;
                        if (s.status_seen) begin
                            s.status_seen = 1'b0;
                            s.flag_bit = 1'b0;
                            s.collision_bit = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_WRITE: begin
                case (i_beat.reg_sel)
                    REG_CTRL: begin
                        s.control_reg = i_beat.write_value;
                        s = apply_mode(s, m_old, cur_mode(s.control_reg));
                        if (cur_mode(s.control_reg) == MODE_LEAD) begin
                            s.clock_level = s.control_reg[CTRL_CPOL];
                        end
                    end
                    REG_STATUS: begin
                        s.double_speed = i_beat.write_value[STAT_2X];
                    end
                    REG_BUFFER: begin
                        s.data_latch = i_beat.write_value;
                        if (s.control_reg[CTRL_SPE]) begin
                            if (s.transfer_active) begin
                                s.collision_bit = 1'b1;
                            end else begin
                                s.shifter = i_beat.write_value;
                                if (m_old == MODE_LEAD) begin
                                    s = frame_start(s);
                                    s.half_bit_timer = half_bit(s.control_reg,
                                                                s.double_speed);
                                end else if (!s.control_reg[CTRL_CPHA]) begin
                                    s.drive_bit = front_bit(s);
                                end
                                s.flag_bit = 1'b0;
                            end
                            s.status_seen = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            CMD_TICK: begin
                if (m_old != MODE_LEAD || i_beat.ss_pin_is_input) begin
                    s = select_update(s, !i_beat.ss_n_in);
                end
                m = cur_mode(s.control_reg);
                if (m == MODE_FOLLOW && s.transfer_active && i_beat.sck_in != s.prev_sck) begin
                    s = clock_edge(s, i_beat.sck_in, i_beat.mosi_in);
                end
                s.prev_sck = i_beat.sck_in;
                if (m == MODE_LEAD && s.transfer_active) begin
                    if (s.half_bit_timer > 7'd1) begin
                        s.half_bit_timer = s.half_bit_timer - 7'd1;
                    end else begin
                        s.clock_level = !s.clock_level;
                        done = frame_done(s);
                        s = clock_edge(s, s.clock_level, i_beat.miso_in);
                        if (done) begin
                            s.transfer_active = 1'b0;
                            s.clock_level = s.control_reg[CTRL_CPOL];
                            s.half_bit_timer = 7'd0;
                        end else begin
                            s.half_bit_timer = half_bit(s.control_reg, s.double_speed);
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        m = cur_mode(s.control_reg);
        o_state = s;
        o_beat.read_data = rd;
        o_beat.sck_out = (m == MODE_LEAD) && s.clock_level;
        o_beat.mosi_out = (m == MODE_LEAD) && s.drive_bit;
        o_beat.miso_out = (m == MODE_FOLLOW) && s.drive_bit;
        o_beat.miso_drive = (m == MODE_FOLLOW) && s.selected_flag;
        o_beat.irq = s.control_reg[CTRL_SPIE] && s.flag_bit;
        o_beat.busy_res = s.transfer_active;
    end

endmodule
`default_nettype wire
